### rtl/core/bts_pkg.sv
// Shared constants, types and helpers for the bilinear texture sampler.
`timescale 1ns / 1ps
`default_nettype none

package bts_pkg;

    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;
    localparam int MAX_DIM    = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
    localparam int DIM_W      = $clog2(MAX_DIM + 1);
    localparam int XW         = $clog2(MAX_WIDTH);
    localparam int YW         = $clog2(MAX_HEIGHT);
    localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW         = $clog2(DEPTH);

    localparam int PIX_W      = 32;
    localparam int FRAC_W     = 16;
    localparam int IP_W       = 16;
    localparam int MAG_W      = IP_W - 1;
    localparam int CNT_W      = $clog2(MAG_W + 1);

    localparam int CFG_IDX_W  = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_X      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_Y      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_EXTEND_MODE  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SMOOTH       = 3'd7;

    localparam logic [1:0] EXT_ZERO   = 2'd0;
    localparam logic [1:0] EXT_REPEAT = 2'd1;
    localparam logic [1:0] EXT_MIRROR = 2'd2;

    localparam logic FUNC_WRITE  = 1'b0;
    localparam logic FUNC_SAMPLE = 1'b1;

    typedef struct packed {
        logic             start;
        logic [IP_W-1:0]  dividend;
        logic [DIM_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic             odd;
        logic [DIM_W-1:0] rem;
    } t_div_res;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [8:0] v, input int maxv);
        if (v == 9'd0) begin
            return DIM_W'(1);
        end else if (32'(v) > maxv) begin
            return DIM_W'(maxv);
        end else begin
            return DIM_W'(v);
        end
    endfunction

endpackage

`default_nettype wire

### rtl/core/bilinear_texture_sampler.sv
// Top level of the bilinear texture sampler: sequencer, mapping, fetch and blend.
`timescale 1ns / 1ps
`default_nettype none

// A write request passes through the write state and then returns to idle. A sample
// request maps both axes, then reads one neighbor in nearest mode and four in bilinear
// mode; repeat and mirror modes add, for each axis, a 15-step restoring divide (one
// quotient bit per cycle) to find its tile. The two coordinate mappings share one
// 32x32 multiplier, the pixel store has a single port read once per neighbor, and
// one four-channel blend unit runs three times per bilinear sample. A finished result
// waits in an output register, so the next request is taken while it is still unread.

module bilinear_texture_sampler (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_func,
    input  logic [7:0]                    i_write_x,
    input  logic [7:0]                    i_write_y,
    input  logic [31:0]                   i_write_pixel,
    input  logic signed [31:0]            i_sample_x,
    input  logic signed [31:0]            i_sample_y,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [31:0]                   o_sample_value,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [bts_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]                   i_cfg_data
);
    import bts_pkg::*;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_WRITE    = 4'd1;
    localparam logic [3:0] S_SUB      = 4'd2;
    localparam logic [3:0] S_MUL      = 4'd3;
    localparam logic [3:0] S_MAP      = 4'd4;
    localparam logic [3:0] S_DIV_GO   = 4'd5;
    localparam logic [3:0] S_DIV_WAIT = 4'd6;
    localparam logic [3:0] S_READ     = 4'd7;
    localparam logic [3:0] S_TAKE     = 4'd8;
    localparam logic [3:0] S_BL_TOP   = 4'd9;
    localparam logic [3:0] S_BL_BOT   = 4'd10;
    localparam logic [3:0] S_BL_OUT   = 4'd11;
    localparam logic [3:0] S_DONE     = 4'd12;

    function automatic logic [PIX_W-1:0] blend(input logic [PIX_W-1:0] a,
                                               input logic [PIX_W-1:0] b,
                                               input logic [FRAC_W-1:0] f);
        logic [24:0]      acc;
        logic [PIX_W-1:0] res;
        res = '0;
        for (int c = 0; c < 4; c++) begin
            acc = 25'(a[8*c +: 8]) * 25'(17'h10000 - 17'(f))
                + 25'(b[8*c +: 8]) * 25'(f) + 25'd32768;
            res[8*c +: 8] = acc[23:16];
        end
        return res;
    endfunction

    logic [3:0]             r_state;
    logic [3:0]             n_state;

    logic [8:0]             r_cfg_width;
    logic [8:0]             r_cfg_height;
    logic [31:0]            r_cfg_org_x;
    logic [31:0]            r_cfg_org_y;
    logic [31:0]            r_cfg_scale_x;
    logic [31:0]            r_cfg_scale_y;
    logic [1:0]             r_cfg_ext;
    logic                   r_cfg_smooth;

    logic [7:0]             r_wx;
    logic [7:0]             r_wy;
    logic [PIX_W-1:0]       r_wpix;
    logic [31:0]            r_sx;
    logic [31:0]            r_sy;

    logic                   r_axis;
    logic [31:0]            r_mag;
    logic                   r_neg;
    logic [63:0]            r_prod;
    logic [IP_W-1:0]        r_ix;
    logic [IP_W-1:0]        r_iy;
    logic [FRAC_W-1:0]      r_fx;
    logic [FRAC_W-1:0]      r_fy;
    logic [DIM_W-1:0]       r_rx;
    logic [DIM_W-1:0]       r_ry;
    logic                   r_odd_x;
    logic                   r_odd_y;

    logic [1:0]             r_tap;
    logic                   r_tap_ok;
    logic [PIX_W-1:0]       r_pix [4];
    logic [PIX_W-1:0]       r_top;
    logic [PIX_W-1:0]       r_bot;
    logic [PIX_W-1:0]       r_result;

    logic                   r_out_valid;
    logic                   n_out_valid;
    logic [PIX_W-1:0]       r_out_value;

    logic                   in_accept;
    logic                   cfg_accept;
    logic                   out_load;
    logic [DIM_W-1:0]       dim_w;
    logic [DIM_W-1:0]       dim_h;
    logic                   wrap_mode;
    logic                   mirror_mode;

    logic [31:0]            sel_coord;
    logic [31:0]            sel_org;
    logic [31:0]            sel_scale;
    logic [32:0]            diff;
    logic [48:0]            map_m;
    logic [31:0]            map_q;

    logic [IP_W:0]          tap_bx;
    logic [IP_W:0]          tap_by;
    logic                   tap_in;
    logic [DIM_W-1:0]       rx_inc;
    logic [DIM_W-1:0]       ry_inc;
    logic                   x_carry;
    logic                   y_carry;
    logic [DIM_W-1:0]       sel_rx;
    logic [DIM_W-1:0]       sel_ry;
    logic                   sel_odd_x;
    logic                   sel_odd_y;
    logic [DIM_W-1:0]       wrap_x;
    logic [DIM_W-1:0]       wrap_y;
    logic [XW-1:0]          tap_x;
    logic [YW-1:0]          tap_y;
    logic                   tap_ok;
    logic [AW-1:0]          tap_addr;

    logic                   wr_ok;
    logic [AW-1:0]          wr_addr;
    logic                   ram_we;
    logic [AW-1:0]          ram_addr;
    logic [PIX_W-1:0]       ram_rdata;
    logic [PIX_W-1:0]       take_pix;

    logic [PIX_W-1:0]       bl_a;
    logic [PIX_W-1:0]       bl_b;
    logic [FRAC_W-1:0]      bl_f;
    logic [PIX_W-1:0]       bl_out;

    t_div_req               div_req;
    t_div_res               div_res;

    assign o_in_ready     = (r_state == S_IDLE);
    assign o_cfg_ready    = 1'b1;
    assign o_out_valid    = r_out_valid;
    assign o_sample_value = r_out_value;

    assign in_accept  = i_in_valid && o_in_ready;
    assign cfg_accept = i_cfg_valid && o_cfg_ready;
    assign out_load   = (r_state == S_DONE) && (!r_out_valid || i_out_ready);

    assign dim_w       = clamp_dim(r_cfg_width, MAX_WIDTH);
    assign dim_h       = clamp_dim(r_cfg_height, MAX_HEIGHT);
    assign wrap_mode   = r_cfg_ext inside {EXT_REPEAT, EXT_MIRROR};
    assign mirror_mode = (r_cfg_ext == EXT_MIRROR);

    // shared coordinate mapping: subtract, multiply, round and saturate
    always_comb begin
        sel_coord = r_axis ? r_sy : r_sx;
        sel_org   = r_axis ? r_cfg_org_y : r_cfg_org_x;
        sel_scale = r_axis ? r_cfg_scale_y : r_cfg_scale_x;
        diff      = {sel_coord[31], sel_coord} - {sel_org[31], sel_org};
        map_m     = {1'b0, r_prod[63:16]} + {48'd0, |r_prod[15:0]};
        if (!r_neg) begin
            map_q = (|r_prod[63:47]) ? 32'h7FFF_FFFF : r_prod[47:16];
        end else if ((|map_m[48:32]) || (map_m[31] && (|map_m[30:0]))) begin
            map_q = 32'h8000_0000;
        end else begin
            map_q = ~map_m[31:0] + 32'd1;
        end
    end

    // neighbor address for the current tap
    always_comb begin
        tap_bx = {r_ix[IP_W-1], r_ix} + (IP_W+1)'(r_tap[0]);
        tap_by = {r_iy[IP_W-1], r_iy} + (IP_W+1)'(r_tap[1]);
        tap_in = !tap_bx[IP_W] && (tap_bx[IP_W-1:0] < IP_W'(dim_w))
              && !tap_by[IP_W] && (tap_by[IP_W-1:0] < IP_W'(dim_h));

        rx_inc    = r_rx + DIM_W'(1);
        ry_inc    = r_ry + DIM_W'(1);
        x_carry   = (rx_inc == dim_w);
        y_carry   = (ry_inc == dim_h);
        sel_rx    = r_tap[0] ? (x_carry ? '0 : rx_inc) : r_rx;
        sel_ry    = r_tap[1] ? (y_carry ? '0 : ry_inc) : r_ry;
        sel_odd_x = r_odd_x ^ (r_tap[0] & x_carry);
        sel_odd_y = r_odd_y ^ (r_tap[1] & y_carry);
        wrap_x    = (mirror_mode && sel_odd_x) ? (dim_w - sel_rx - DIM_W'(1)) : sel_rx;
        wrap_y    = (mirror_mode && sel_odd_y) ? (dim_h - sel_ry - DIM_W'(1)) : sel_ry;

        tap_x    = wrap_mode ? wrap_x[XW-1:0] : tap_bx[XW-1:0];
        tap_y    = wrap_mode ? wrap_y[YW-1:0] : tap_by[YW-1:0];
        tap_ok   = wrap_mode || tap_in;
        tap_addr = AW'(tap_y) * AW'(MAX_WIDTH) + AW'(tap_x);
    end

    assign wr_ok    = (32'(r_wx) < MAX_WIDTH) && (32'(r_wy) < MAX_HEIGHT);
    assign wr_addr  = AW'(r_wy) * AW'(MAX_WIDTH) + AW'(r_wx);
    assign ram_we   = (r_state == S_WRITE) && wr_ok;
    assign ram_addr = (r_state == S_WRITE) ? wr_addr : tap_addr;
    assign take_pix = r_tap_ok ? ram_rdata : '0;

    bts_ram #(
        .WIDTH (PIX_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (r_wpix),
        .o_rdata (ram_rdata)
    );

    assign div_req.start    = (r_state == S_DIV_GO);
    assign div_req.dividend = r_axis ? r_iy : r_ix;
    assign div_req.divisor  = r_axis ? dim_h : dim_w;

    bts_wrap_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_res   (div_res)
    );

    always_comb begin
        case (r_state)
            S_BL_TOP: begin
                bl_a = r_pix[0];
                bl_b = r_pix[1];
                bl_f = r_fx;
            end
            S_BL_BOT: begin
                bl_a = r_pix[2];
                bl_b = r_pix[3];
                bl_f = r_fx;
            end
            default: begin
                bl_a = r_top;
                bl_b = r_bot;
                bl_f = r_fy;
            end
        endcase
        bl_out = blend(bl_a, bl_b, bl_f);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_state = (i_func == FUNC_WRITE) ? S_WRITE : S_SUB;
                end
            end
            S_WRITE:    n_state = S_IDLE;
            S_SUB:      n_state = S_MUL;
            S_MUL:      n_state = S_MAP;
            S_MAP: begin
                if (!r_axis) begin
                    n_state = S_SUB;
                end else if (wrap_mode) begin
                    n_state = S_DIV_GO;
                end else begin
                    n_state = S_READ;
                end
            end
            S_DIV_GO:   n_state = S_DIV_WAIT;
            S_DIV_WAIT: begin
                if (div_res.done) begin
                    n_state = r_axis ? S_READ : S_DIV_GO;
                end
            end
            S_READ:     n_state = S_TAKE;
            S_TAKE: begin
                if (!r_cfg_smooth) begin
                    n_state = S_DONE;
                end else if (r_tap == 2'd3) begin
                    n_state = S_BL_TOP;
                end else begin
                    n_state = S_READ;
                end
            end
            S_BL_TOP:   n_state = S_BL_BOT;
            S_BL_BOT:   n_state = S_BL_OUT;
            S_BL_OUT:   n_state = S_DONE;
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default:    n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        if (out_load) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_out_valid   <= 1'b0;
            r_axis        <= 1'b0;
            r_tap         <= '0;
            r_cfg_width   <= 9'd256;
            r_cfg_height  <= 9'd256;
            r_cfg_org_x   <= '0;
            r_cfg_org_y   <= '0;
            r_cfg_scale_x <= 32'd65536;
            r_cfg_scale_y <= 32'd65536;
            r_cfg_ext     <= EXT_ZERO;
            r_cfg_smooth  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;

            case (r_state)
                S_IDLE: begin
                    r_axis <= 1'b0;
                end
                S_MAP: begin
                    r_axis <= !r_axis;
                    r_tap  <= '0;
                end
                S_DIV_WAIT: begin
                    if (div_res.done) begin
                        r_axis <= !r_axis;
                    end
                end
                S_TAKE: begin
                    r_tap <= r_tap + 2'd1;
                end
                default: begin
                end
            endcase

            if (cfg_accept) begin
                case (i_cfg_index)
                    CFG_IMAGE_WIDTH:  r_cfg_width   <= i_cfg_data[8:0];
                    CFG_IMAGE_HEIGHT: r_cfg_height  <= i_cfg_data[8:0];
                    CFG_ORIGIN_X:     r_cfg_org_x   <= i_cfg_data;
                    CFG_ORIGIN_Y:     r_cfg_org_y   <= i_cfg_data;
                    CFG_SCALE_X:      r_cfg_scale_x <= i_cfg_data;
                    CFG_SCALE_Y:      r_cfg_scale_y <= i_cfg_data;
                    CFG_EXTEND_MODE:  r_cfg_ext     <= i_cfg_data[1:0];
                    CFG_SMOOTH:       r_cfg_smooth  <= i_cfg_data[0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_wx   <= i_write_x;
            r_wy   <= i_write_y;
            r_wpix <= i_write_pixel;
            r_sx   <= i_sample_x;
            r_sy   <= i_sample_y;
        end

        case (r_state)
            S_SUB: begin
                r_neg <= diff[32];
                r_mag <= diff[32] ? (~diff[31:0] + 32'd1) : diff[31:0];
            end
            S_MUL: begin
                r_prod <= 64'(r_mag) * 64'(sel_scale);
            end
            S_MAP: begin
                if (r_axis) begin
                    r_iy <= map_q[31:FRAC_W];
                    r_fy <= map_q[FRAC_W-1:0];
                end else begin
                    r_ix <= map_q[31:FRAC_W];
                    r_fx <= map_q[FRAC_W-1:0];
                end
            end
            S_DIV_WAIT: begin
                if (div_res.done) begin
                    if (r_axis) begin
                        r_ry    <= div_res.rem;
                        r_odd_y <= div_res.odd;
                    end else begin
                        r_rx    <= div_res.rem;
                        r_odd_x <= div_res.odd;
                    end
                end
            end
            S_READ: begin
                r_tap_ok <= tap_ok;
            end
            S_TAKE: begin
                r_pix[r_tap] <= take_pix;
                r_result     <= take_pix;
            end
            S_BL_TOP: begin
                r_top <= bl_out;
            end
            S_BL_BOT: begin
                r_bot <= bl_out;
            end
            S_BL_OUT: begin
                r_result <= bl_out;
            end
            default: begin
            end
        endcase

        if (out_load) begin
            r_out_value <= r_result;
        end
    end

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (r_state != S_IDLE))
        else $error("request accepted without leaving idle");

    a_div_rem_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_res.done |-> (div_res.rem < div_req.divisor))
        else $error("wrap remainder not below tile size");

    a_wrap_tap_in_image: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_READ) && wrap_mode)
            |-> ((DIM_W'(tap_x) < dim_w) && (DIM_W'(tap_y) < dim_h)))
        else $error("wrapped neighbor outside image");

    a_done_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_DONE) && !r_out_valid) |=> (r_out_valid && (r_state == S_IDLE)))
        else $error("finished sample not moved to output register");

endmodule

`default_nettype wire

### rtl/core/bts_ram.sv
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none

module bts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### rtl/core/bts_wrap_div.sv
// Restoring divider for tile wrap: floored remainder and tile parity.
`timescale 1ns / 1ps
`default_nettype none

module bts_wrap_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bts_pkg::t_div_req i_req,
    output bts_pkg::t_div_res o_res
);
    import bts_pkg::*;

    logic             r_run;
    logic [CNT_W-1:0] r_cnt;
    logic             r_neg;
    logic [DIM_W-1:0] r_div;
    logic [DIM_W-1:0] r_rem;
    logic [MAG_W-1:0] r_mag;
    logic             r_q0;

    logic [DIM_W:0]   trial;
    logic [DIM_W:0]   trial_sub;
    logic             trial_ge;

    always_comb begin
        trial     = {r_rem, r_mag[MAG_W-1]};
        trial_sub = trial - {1'b0, r_div};
        trial_ge  = (trial >= {1'b0, r_div});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
            r_cnt <= '0;
        end else if (i_req.start) begin
            r_run <= 1'b1;
            r_cnt <= CNT_W'(MAG_W);
        end else if (r_run) begin
            if (r_cnt == '0) begin
                r_run <= 1'b0;
            end else begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

    // negative index i divides as -i-1, then folds back
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_neg <= i_req.dividend[IP_W-1];
            r_mag <= i_req.dividend[IP_W-1] ? ~i_req.dividend[MAG_W-1:0]
                                            : i_req.dividend[MAG_W-1:0];
            r_div <= i_req.divisor;
            r_rem <= '0;
            r_q0  <= 1'b0;
        end else if (r_run && (r_cnt != '0)) begin
            r_rem <= trial_ge ? trial_sub[DIM_W-1:0] : trial[DIM_W-1:0];
            r_mag <= {r_mag[MAG_W-2:0], 1'b0};
            r_q0  <= trial_ge;
        end
    end

    assign o_res.done = r_run && (r_cnt == '0);
    assign o_res.odd  = r_q0 ^ r_neg;
    assign o_res.rem  = r_neg ? (r_div - r_rem - DIM_W'(1)) : r_rem;

endmodule

`default_nettype wire
